### design/ms2c_pkg.sv
// ----------------------------------------------------------------------------
// ms2c_pkg
// Shared constants, beat indexes and the digit bundle for the millisecond
// to mm:ss:mmm lcd writer.
// ----------------------------------------------------------------------------
package ms2c_pkg;

  // default width of the elapsed time input
  localparam int VALUE_BITS_DEF = 16;

  // column register
  localparam int              COL_W     = 6;
  localparam logic [COL_W-1:0] COL_RESET = 6'd7;

  // time units
  localparam int MS_PER_MIN = 60000;
  localparam int MS_PER_SEC = 1000;

  // minute count width at the widest input (2^32 / 60000 < 2^17)
  localparam int MIN_W = 17;

  // reciprocal constants, each underestimates the quotient by at most one
  localparam int          RECIP_MIN_SHIFT = 47;
  localparam logic [31:0] RECIP_MIN       = 32'd2345624805;
  localparam int          RECIP_100_SHIFT = 24;
  localparam logic [17:0] RECIP_100       = 18'd167772;
  localparam int          RECIP_SEC_SHIFT = 26;
  localparam logic [16:0] RECIP_SEC       = 17'd67108;

  // lcd bytes
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_COLON = 8'h3A;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_ROW1    = 8'h80;

  // beats of one write sequence
  localparam int NUM_WRITES = 11;
  localparam int BEAT_W     = 4;
  localparam logic [BEAT_W-1:0] BEAT_CLEAR   = 4'd0;
  localparam logic [BEAT_W-1:0] BEAT_CURSOR  = 4'd1;
  localparam logic [BEAT_W-1:0] BEAT_MIN_T   = 4'd2;
  localparam logic [BEAT_W-1:0] BEAT_MIN_O   = 4'd3;
  localparam logic [BEAT_W-1:0] BEAT_COLON_A = 4'd4;
  localparam logic [BEAT_W-1:0] BEAT_SEC_T   = 4'd5;
  localparam logic [BEAT_W-1:0] BEAT_SEC_O   = 4'd6;
  localparam logic [BEAT_W-1:0] BEAT_COLON_B = 4'd7;
  localparam logic [BEAT_W-1:0] BEAT_MS_H    = 4'd8;
  localparam logic [BEAT_W-1:0] BEAT_MS_T    = 4'd9;
  localparam logic [BEAT_W-1:0] BEAT_MS_O    = 4'd10;

  // decimal digits of one time value
  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [3:0] sec_tens;
    logic [3:0] sec_ones;
    logic [3:0] ms_hund;
    logic [3:0] ms_tens;
    logic [3:0] ms_ones;
  } digits_t;

endpackage

### design/ms2c_conv.sv
// ----------------------------------------------------------------------------
// ms2c_conv
// Ten stage pipeline that splits a millisecond count into minute, second
// and millisecond digits using reciprocal multiplies with one correction.
// ----------------------------------------------------------------------------
module ms2c_conv
  import ms2c_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  dig_valid,
  output digits_t               digits
);

  localparam int PROD_W  = VALUE_BITS + 32;
  localparam int QW      = VALUE_BITS - 15;
  localparam int QMUL_W  = VALUE_BITS + 1;
  localparam int REM0_W  = 17;
  localparam int NSTAGE  = 10;

  // valid bits, one per stage
  logic [NSTAGE-1:0] vld;

  // stage registers
  logic [VALUE_BITS-1:0] v1, v2;
  logic [PROD_W-1:0]     prod2;
  logic [QW-1:0]         q3;
  logic [REM0_W-1:0]     rem3;
  logic [MIN_W-1:0]      min4, min5;
  logic [15:0]           rem4, rem5;
  logic [MIN_W+17:0]     prodm5;
  logic [32:0]           prods5;
  logic [7:0]            mr6;
  logic [10:0]           sr6;
  logic [5:0]            sq6;
  logic [6:0]            mm7, mm8;
  logic [5:0]            sec7, sec8;
  logic [9:0]            ms7, ms8;
  logic [3:0]            mm_t8, sec_t8, ms_h8;
  logic [3:0]            mm_t9, sec_t9, ms_h9, mm_o9, sec_o9;
  logic [6:0]            ms_r9;

  // combinational helpers
  logic [QW-1:0]     q_est;
  logic [QMUL_W-1:0] q_mul;
  logic [QMUL_W-1:0] rem_full;
  logic [10:0]       mq;
  logic [MIN_W-1:0]  mr_full;
  logic [6:0]        sq;
  logic [15:0]       sr_full;
  logic [14:0]       mm_p, sec_p, msr_p;
  logic [15:0]       msh_p;
  logic [6:0]        mm_o_full, sec_o_full, ms_r_full, ms_o_full;
  logic [3:0]        ms_t10;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  // minute quotient estimate and remainder
  always_comb begin
    q_est    = prod2[PROD_W-1 -: QW];
    q_mul    = QMUL_W'(q_est) * QMUL_W'(MS_PER_MIN);
    rem_full = QMUL_W'(v2) - q_mul;
  end

  // hundreds of minutes and thousands of the remainder
  always_comb begin
    mq      = prodm5[MIN_W+17 -: 11];
    mr_full = min5 - MIN_W'(MIN_W'(mq) * MIN_W'(100));
    sq      = prods5[32 -: 7];
    sr_full = rem5 - 16'(16'(sq) * 16'(MS_PER_SEC));
  end

  // decimal digit split by small reciprocal multiplies
  always_comb begin
    mm_p       = 15'(mm7) * 15'(205);
    sec_p      = 15'(sec7) * 15'(205);
    msh_p      = 16'(ms7) * 16'(41);
    mm_o_full  = mm8 - 7'(mm_t8 * 7'd10);
    sec_o_full = 7'(sec8) - 7'(sec_t8 * 7'd10);
    ms_r_full  = 7'(ms8 - 10'(ms_h8 * 10'd100));
    msr_p      = 15'(ms_r9) * 15'(205);
    ms_t10     = msr_p[14:11];
    ms_o_full  = ms_r9 - 7'(ms_t10 * 7'd10);
  end

  // payload stages
  always_ff @(posedge clk) begin
    // stage 1: capture
    v1     <= value;
    // stage 2: reciprocal multiply for minutes
    v2     <= v1;
    prod2  <= PROD_W'(v1) * PROD_W'(RECIP_MIN);
    // stage 3: quotient estimate and remainder
    q3     <= q_est;
    rem3   <= rem_full[REM0_W-1:0];
    // stage 4: correction
    if (rem3 >= REM0_W'(MS_PER_MIN)) begin
      min4 <= MIN_W'(q3) + MIN_W'(1);
      rem4 <= 16'(rem3 - REM0_W'(MS_PER_MIN));
    end else begin
      min4 <= MIN_W'(q3);
      rem4 <= rem3[15:0];
    end
    // stage 5: reciprocal multiplies for minutes mod 100 and seconds
    min5   <= min4;
    rem5   <= rem4;
    prodm5 <= (MIN_W+18)'(min4) * (MIN_W+18)'(RECIP_100);
    prods5 <= 33'(rem4) * 33'(RECIP_SEC);
    // stage 6: remainders
    mr6    <= mr_full[7:0];
    sr6    <= sr_full[10:0];
    sq6    <= sq[5:0];
    // stage 7: corrections
    if (mr6 >= 8'd100) begin
      mm7 <= 7'(mr6 - 8'd100);
    end else begin
      mm7 <= mr6[6:0];
    end
    if (sr6 >= 11'(MS_PER_SEC)) begin
      sec7 <= sq6 + 6'd1;
      ms7  <= 10'(sr6 - 11'(MS_PER_SEC));
    end else begin
      sec7 <= sq6;
      ms7  <= sr6[9:0];
    end
    // stage 8: tens and hundreds
    mm8    <= mm7;
    sec8   <= sec7;
    ms8    <= ms7;
    mm_t8  <= mm_p[14:11];
    sec_t8 <= sec_p[14:11];
    ms_h8  <= msh_p[15:12];
    // stage 9: ones and millisecond remainder
    mm_t9  <= mm_t8;
    sec_t9 <= sec_t8;
    ms_h9  <= ms_h8;
    mm_o9  <= mm_o_full[3:0];
    sec_o9 <= sec_o_full[3:0];
    ms_r9  <= ms_r_full;
    // stage 10: last millisecond digits
    digits.min_tens <= mm_t9;
    digits.min_ones <= mm_o9;
    digits.sec_tens <= sec_t9;
    digits.sec_ones <= sec_o9;
    digits.ms_hund  <= ms_h9;
    digits.ms_tens  <= ms_t10;
    digits.ms_ones  <= ms_o_full[3:0];
  end

  assign dig_valid = vld[NSTAGE-1];

endmodule

### design/ms2c_emit.sv
// ----------------------------------------------------------------------------
// ms2c_emit
// Beat sequencer: turns one set of digits into the eleven lcd writes,
// one per cycle, from registered outputs.
// ----------------------------------------------------------------------------
module ms2c_emit
  import ms2c_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             dig_valid,
  input  digits_t          digits,
  input  logic [COL_W-1:0] start_column,
  output logic             result_strobe,
  output logic             is_data,
  output logic [7:0]       lcd_byte,
  output logic             last
);

  localparam logic [BEAT_W-1:0] BEAT_END = BEAT_W'(NUM_WRITES - 1);

  logic              active;
  logic [BEAT_W-1:0] beat;
  digits_t           held;
  logic [7:0]        byte_next;

  // byte for the current beat
  always_comb begin
    unique case (beat)
      BEAT_CLEAR:   byte_next = CMD_CLEAR;
      BEAT_CURSOR:  byte_next = CMD_ROW1 + 8'(start_column);
      BEAT_MIN_T:   byte_next = ASCII_ZERO + 8'(held.min_tens);
      BEAT_MIN_O:   byte_next = ASCII_ZERO + 8'(held.min_ones);
      BEAT_COLON_A: byte_next = ASCII_COLON;
      BEAT_SEC_T:   byte_next = ASCII_ZERO + 8'(held.sec_tens);
      BEAT_SEC_O:   byte_next = ASCII_ZERO + 8'(held.sec_ones);
      BEAT_COLON_B: byte_next = ASCII_COLON;
      BEAT_MS_H:    byte_next = ASCII_ZERO + 8'(held.ms_hund);
      BEAT_MS_T:    byte_next = ASCII_ZERO + 8'(held.ms_tens);
      BEAT_MS_O:    byte_next = ASCII_ZERO + 8'(held.ms_ones);
      default:      byte_next = CMD_CLEAR;
    endcase
  end

  // sequence control and strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      beat          <= BEAT_CLEAR;
      result_strobe <= 1'b0;
      last          <= 1'b0;
    end else begin
      result_strobe <= active;
      last          <= active && (beat == BEAT_END);
      if (dig_valid) begin
        active <= 1'b1;
        beat   <= BEAT_CLEAR;
      end else if (active) begin
        if (beat == BEAT_END) begin
          active <= 1'b0;
        end else begin
          beat <= beat + BEAT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (dig_valid) begin
      held <= digits;
    end
    is_data  <= (beat != BEAT_CLEAR) && (beat != BEAT_CURSOR);
    lcd_byte <= byte_next;
  end

endmodule

### design/ms_to_clock_lcd_writer_top.sv
// ----------------------------------------------------------------------------
// ms_to_clock_lcd_writer_top
// Milliseconds to mm:ss:mmm character lcd writer.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive elapsed_ms and raise start; the value is taken at a clock
//   edge where start is high and busy is low. busy stays high after each
//   accepted beat until the spacing counter runs down, and a new value can
//   be taken while earlier values are still in the divider pipeline or
//   being written out.
//   Output: each value gives eleven writes on consecutive cycles, each
//   marked by result_strobe for one cycle: clear display, cursor to row
//   one at start_column, then the characters M M : S S : m m m. last
//   is high on the eleventh write. The first write follows the accept
//   edge through the ten conversion stages, the sequencer beat register
//   and the output register. The sustained rate is set by the busy counter
//   to match the one-write-per-cycle lcd bus in the output sequencer.
//   Config: start_column is written through cfg_valid/cfg_ready/cfg_data,
//   always ready; write it only while no value is in flight.
//   Reset: rst clears the pipeline valid bits, the sequencer and busy, and
//   sets start_column to 7. The receiver cannot stall; writes are not held.
// ----------------------------------------------------------------------------
module ms_to_clock_lcd_writer_top
  import ms2c_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] elapsed_ms,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COL_W-1:0]      cfg_data,
  output logic                  result_strobe,
  output logic                  is_data,
  output logic [7:0]            lcd_byte,
  output logic                  last
);

  localparam logic [BEAT_W-1:0] GAP_LOAD = BEAT_W'(NUM_WRITES - 1);

  logic              accept;
  logic [BEAT_W-1:0] gap;
  logic [BEAT_W-1:0] gap_next;
  logic [COL_W-1:0]  start_column;
  logic              dig_valid;
  digits_t           digits;

  assign accept    = start && !busy;
  assign busy      = (gap != '0);
  assign cfg_ready = 1'b1;

  // spacing counter between accepted beats
  always_comb begin
    if (accept) begin
      gap_next = GAP_LOAD;
    end else if (gap != '0) begin
      gap_next = gap - BEAT_W'(1);
    end else begin
      gap_next = gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else begin
      gap <= gap_next;
    end
  end

  // column register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_column <= COL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      start_column <= cfg_data;
    end
  end

  // digit pipeline
  ms2c_conv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_conv (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .value    (elapsed_ms),
    .dig_valid(dig_valid),
    .digits   (digits)
  );

  // write sequencer
  ms2c_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .dig_valid    (dig_valid),
    .digits       (digits),
    .start_column (start_column),
    .result_strobe(result_strobe),
    .is_data      (is_data),
    .lcd_byte     (lcd_byte),
    .last         (last)
  );

endmodule

### design/ms2c_chk.sv
// ----------------------------------------------------------------------------
// ms2c_chk
// Port level checks for the lcd writer, bound to the top level.
// ----------------------------------------------------------------------------
module ms2c_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_strobe,
  input logic is_data,
  input logic last
);

  // the final write is a strobed character write
  a_last_data: assert property (@(posedge clk) disable iff (rst)
    last |-> (result_strobe && is_data))
    else $error("last without a strobed data write");

  // an accepted beat blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after an accept");

  // writes of one sequence come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last) |=> result_strobe)
    else $error("gap inside a write sequence");

  // a sequence is eleven writes opening with a command
  a_length: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last) |-> ($past(result_strobe, 10) && !$past(is_data, 10)))
    else $error("write sequence of wrong length");

endmodule

bind ms_to_clock_lcd_writer_top ms2c_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_strobe(result_strobe),
  .is_data      (is_data),
  .last         (last)
);
